>>> design/dll_pkg.sv
// ----------------------------------------------------------------------------
// dll_pkg
// Shared codes for the bounded doubly linked list: commands, status and cell ops.
// ----------------------------------------------------------------------------
package dll_pkg;

  typedef enum logic [1:0] {
    CMD_HEAD   = 2'd0,
    CMD_TAIL   = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_ROTATE     = 3'd3,
    OP_DROP       = 3'd4
  } cell_op_t;

endpackage

>>> design/bounded_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list
// Bounded list of signed values held in a chain of cells, head in cell zero.
// ----------------------------------------------------------------------------
// usage
//   s_axis: one command item; tuser holds cmd (insert head, insert tail,
//   delete first match, read out), tdata holds the value
//   m_axis: result items; tdata holds the element value, tuser the status,
//   tlast marks the final result of a command
//   insert: its result is registered and can be taken in the cycle after acceptance
//   delete: walks the list through cell zero, one element a cycle; its one
//   result is registered at the last step of the walk
//   read out: same walk, one result per element, head to tail, each result
//   registered as its element passes cell zero, one a cycle while m_axis is ready
//   empty read out gives one empty status item, delete of a missing value
//   a not found item, insert into a full list a full status item
//   a new command is taken once the walk is done and the result register is
//   free or draining; m_axis stalls hold read outs
//   reset empties the list at once; cell contents need no clearing
// ----------------------------------------------------------------------------
module bounded_doubly_linked_list #(
  parameter int LIST_DEPTH  = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value
  input  logic [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // item_value
  output logic [1:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast
);
  import dll_pkg::*;

  localparam int LW = $clog2(LIST_DEPTH + 1);

  cell_op_t              op;
  logic [LW-1:0]         len;
  logic [VALUE_WIDTH-1:0] new_val;
  logic [VALUE_WIDTH-1:0] cell_val [LIST_DEPTH];

  dll_ctrl #(
    .DEPTH (LIST_DEPTH),
    .VW    (VALUE_WIDTH),
    .LW    (LW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (s_axis_tuser),
    .in_value   (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_value  (m_axis_tdata),
    .out_status (m_axis_tuser),
    .out_last   (m_axis_tlast),
    .op         (op),
    .len        (len),
    .new_val    (new_val),
    .front_val  (cell_val[0])
  );

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    dll_cell #(
      .VW    (VALUE_WIDTH),
      .LW    (LW),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .len       (len),
      .left_val  ((i == 0) ? new_val : cell_val[(i == 0) ? 0 : i - 1]),
      .right_val (cell_val[(i == LIST_DEPTH - 1) ? i : i + 1]),
      .wrap_val  (cell_val[0]),
      .new_val   (new_val),
      .val       (cell_val[i])
    );
  end

endmodule

>>> design/dll_cell.sv
// ----------------------------------------------------------------------------
// dll_cell
// One element position of the list chain; takes data from a neighbor, cell zero or the new value per op.
// ----------------------------------------------------------------------------
module dll_cell #(
  parameter int VW    = 32,
  parameter int LW    = 5,
  parameter int IDX   = 0
) (
  input  logic               clk,
  input  dll_pkg::cell_op_t  op,
  input  logic [LW-1:0]      len,
  input  logic [VW-1:0]      left_val,
  input  logic [VW-1:0]      right_val,
  input  logic [VW-1:0]      wrap_val,
  input  logic [VW-1:0]      new_val,
  output logic [VW-1:0]      val
);
  import dll_pkg::*;

  localparam logic [LW-1:0] IDX_L  = LW'(IDX);
  localparam logic [LW-1:0] IDX_P1 = LW'(IDX + 1);

  logic [VW-1:0] val_next;

  always_comb begin
    val_next = val;
    unique case (op)
      OP_PUSH_FRONT: val_next = (IDX == 0) ? new_val : left_val;
      OP_PUSH_BACK: begin
        if (IDX_L == len) val_next = new_val;
      end
      OP_ROTATE: begin
        if (IDX_P1 < len) val_next = right_val;
        else if (IDX_P1 == len) val_next = wrap_val;
      end
      OP_DROP: begin
        if (IDX_P1 < len) val_next = right_val;
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

>>> design/dll_ctrl.sv
// ----------------------------------------------------------------------------
// dll_ctrl
// Command sequencer: length, walk counter, match search and result register.
// ----------------------------------------------------------------------------
module dll_ctrl #(
  parameter int DEPTH = 16,
  parameter int VW    = 32,
  parameter int LW    = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [31:0]        in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_value,
  output logic [1:0]         out_status,
  output logic               out_last,
  output dll_pkg::cell_op_t  op,
  output logic [LW-1:0]      len,
  output logic [VW-1:0]      new_val,
  input  logic [VW-1:0]      front_val
);
  import dll_pkg::*;

  localparam logic [LW-1:0] FULL_LEN = LW'(DEPTH);
  localparam logic [LW-1:0] ONE_LEN  = LW'(1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t          state;
  logic [LW-1:0]   remain;
  logic            is_read;
  logic            found;
  logic [VW-1:0]   key;

  logic [VW+31:0]  in_wide;
  logic [VW+31:0]  front_wide;
  logic            slot_free;
  logic            accept;
  logic            step;
  logic            drop_now;
  cmd_t            cmd;

  assign cmd        = cmd_t'(in_cmd);
  assign in_wide    = {{VW{in_value[31]}}, in_value};
  assign new_val    = in_wide[VW-1:0];
  assign front_wide = {{32{front_val[VW-1]}}, front_val};
  assign slot_free  = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE) && slot_free;
  assign accept     = in_valid && in_ready;
  assign step       = (state == S_WALK) && slot_free;
  assign drop_now   = !is_read && !found && (front_val == key);

  always_comb begin
    op = OP_HOLD;
    if (accept && len != FULL_LEN && cmd == CMD_HEAD) op = OP_PUSH_FRONT;
    else if (accept && len != FULL_LEN && cmd == CMD_TAIL) op = OP_PUSH_BACK;
    else if (step) op = drop_now ? OP_DROP : OP_ROTATE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      remain    <= '0;
      is_read   <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            out_valid  <= 1'b1;
            out_value  <= '0;
            out_last   <= 1'b1;
            out_status <= ST_OK;
            key        <= new_val;
            is_read    <= (cmd == CMD_READ);
            found      <= 1'b0;
            remain     <= len;
            unique case (cmd)
              CMD_HEAD, CMD_TAIL: begin
                if (len == FULL_LEN) out_status <= ST_FULL;
                else len <= len + ONE_LEN;
              end
              CMD_DELETE: begin
                if (len == '0) out_status <= ST_NOTFOUND;
                else begin
                  out_valid <= 1'b0;
                  state     <= S_WALK;
                end
              end
              CMD_READ: begin
                if (len == '0) out_status <= ST_EMPTY;
                else begin
                  out_valid <= 1'b0;
                  state     <= S_WALK;
                end
              end
              default: out_status <= ST_OK;
            endcase
          end
        end
        S_WALK: begin
          if (step) begin
            remain <= remain - ONE_LEN;
            if (drop_now) begin
              found <= 1'b1;
              len   <= len - ONE_LEN;
            end
            if (is_read) begin
              out_valid  <= 1'b1;
              out_value  <= front_wide[31:0];
              out_status <= ST_OK;
              out_last   <= (remain == ONE_LEN);
            end else if (remain == ONE_LEN) begin
              out_valid  <= 1'b1;
              out_value  <= '0;
              out_status <= (found || drop_now) ? ST_OK : ST_NOTFOUND;
              out_last   <= 1'b1;
            end
            if (remain == ONE_LEN) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> dv/bounded_doubly_linked_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list_tb
// Self-checking bench for the bounded doubly linked list. A directed run walks
// the empty, duplicate, head, middle and tail delete cases, then random
// traffic alternates between filling the list past full and draining it.
// A local list model predicts every result item. Both stream sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module bounded_doubly_linked_list_tb;
  import dll_pkg::*;

  localparam int LIST_DEPTH   = 16;
  localparam int VALUE_WIDTH  = 32;
  localparam int RANDOM_CMDS  = 320;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] value;
    bit          wait_idle;
  } list_cmd_t;

  typedef struct {
    logic [31:0] item_value;
    status_t     status;
    logic        is_last;
  } list_result_t;

  typedef enum {RX_FREE, RX_CHOPPY, RX_SLOW} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // value
  logic [1:0]  s_axis_tuser = '0;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // item_value
  logic [1:0]  m_axis_tuser;        // status
  logic        m_axis_tlast;

  list_cmd_t    cmd_q[$];
  list_result_t result_q[$];
  logic [31:0]  list_vals[$];
  logic [31:0]  shadow_vals[$];

  int outstanding = 0;
  int error_count = 0;
  int cmd_count = 0;
  int result_count = 0;
  int full_count = 0;
  int miss_count = 0;
  int empty_count = 0;

  bounded_doubly_linked_list #(
    .LIST_DEPTH (LIST_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endtask

  function automatic void push_result(input logic [31:0] v, input status_t st,
                                      input logic is_last);
    list_result_t r;
    r.item_value = v;
    r.status     = st;
    r.is_last    = is_last;
    result_q.push_back(r);
    result_count++;
    if (st == ST_FULL) full_count++;
    if (st == ST_NOTFOUND) miss_count++;
    if (st == ST_EMPTY) empty_count++;
  endfunction

  // list model, head at index zero
  function automatic void apply_list_cmd(input cmd_t cmd, input logic [31:0] v);
    int hit;
    hit = -1;
    cmd_count++;
    case (cmd)
      CMD_HEAD, CMD_TAIL: begin
        if (list_vals.size() >= LIST_DEPTH) begin
          push_result('0, ST_FULL, 1'b1);
        end else begin
          if (cmd == CMD_HEAD) list_vals.push_front(v);
          else list_vals.push_back(v);
          push_result('0, ST_OK, 1'b1);
        end
      end
      CMD_DELETE: begin
        foreach (list_vals[i]) if (hit < 0 && list_vals[i] == v) hit = i;
        if (hit < 0) begin
          push_result('0, ST_NOTFOUND, 1'b1);
        end else begin
          list_vals.delete(hit);
          push_result('0, ST_OK, 1'b1);
        end
      end
      default: begin
        if (list_vals.size() == 0) push_result('0, ST_EMPTY, 1'b1);
        else foreach (list_vals[i]) push_result(list_vals[i], ST_OK, i == list_vals.size() - 1);
      end
    endcase
  endfunction

  // stimulus side keeps its own view of the contents to aim deletes and fills
  task automatic add_cmd(input cmd_t cmd, input logic [31:0] v, input bit wait_idle);
    list_cmd_t c;
    int hit;
    hit = -1;
    c.cmd       = cmd;
    c.value     = v;
    c.wait_idle = wait_idle;
    cmd_q.push_back(c);
    if ((cmd == CMD_HEAD || cmd == CMD_TAIL) && shadow_vals.size() < LIST_DEPTH) begin
      if (cmd == CMD_HEAD) shadow_vals.push_front(v);
      else shadow_vals.push_back(v);
    end else if (cmd == CMD_DELETE) begin
      foreach (shadow_vals[i]) if (hit < 0 && shadow_vals[i] == v) hit = i;
      if (hit >= 0) shadow_vals.delete(hit);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'($urandom_range(1, 3));
      default: return $urandom;
    endcase
  endfunction

  // sender: bursts with random gaps, optional wait for an idle block
  int  burst_left = 0;
  int  gap_left = 0;
  bit  took;
  list_cmd_t next_cmd;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      took = s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && !took) begin
        // hold the item until it is taken
      end else if (gap_left > 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q[0].wait_idle && (took || outstanding != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        next_cmd = cmd_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_cmd.value;
        s_axis_tuser  <= next_cmd.cmd;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: free, choppy and slow stretches plus two long hold-offs
  rx_mode_t rx_mode = RX_FREE;
  int rx_stretch = 0;
  int rx_taken = 0;
  int hold_left = 0;
  int holds_done = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) rx_taken++;
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if ((holds_done == 0 && rx_taken >= 50) ||
                   (holds_done == 1 && rx_taken >= 400)) begin
        hold_left     <= HOLD_CYCLES;
        holds_done    <= holds_done + 1;
        m_axis_tready <= 1'b0;
      end else begin
        if (rx_stretch == 0) begin
          rx_mode    = rx_mode_t'($urandom_range(0, 2));
          rx_stretch = $urandom_range(5, 60);
        end else begin
          rx_stretch--;
        end
        case (rx_mode)
          RX_FREE:   m_axis_tready <= 1'b1;
          RX_CHOPPY: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor: check results against the oldest prediction, then predict
  list_result_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          note_failure($sformatf("unexpected item value=%h status=%0d last=%b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata !== want.item_value || m_axis_tuser !== want.status ||
              m_axis_tlast !== want.is_last)
            note_failure($sformatf(
              "exp value=%h status=%0d last=%b, got value=%h status=%0d last=%b",
              want.item_value, want.status, want.is_last,
              m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        apply_list_cmd(cmd_t'(s_axis_tuser), s_axis_tdata);
      outstanding <= result_q.size();
    end
  end

  int  cycles;
  int  roll;
  int  full_tries;
  bit  grow;
  bit  done;
  cmd_t rcmd;
  logic [31:0] rval;

  initial begin
    // directed: empty list, extremes, duplicates, head/middle/tail deletes
    add_cmd(CMD_READ,   $urandom, 1'b0);
    add_cmd(CMD_DELETE, 32'd5, 1'b0);
    add_cmd(CMD_HEAD,   32'h8000_0000, 1'b0);
    add_cmd(CMD_TAIL,   32'h7fff_ffff, 1'b0);
    add_cmd(CMD_HEAD,   32'hffff_ffff, 1'b0);
    add_cmd(CMD_TAIL,   32'h0000_0000, 1'b0);
    add_cmd(CMD_TAIL,   32'h7fff_ffff, 1'b0);
    add_cmd(CMD_READ,   32'hffff_ffff, 1'b0);
    add_cmd(CMD_DELETE, 32'h7fff_ffff, 1'b0);
    add_cmd(CMD_READ,   32'h0, 1'b0);
    add_cmd(CMD_DELETE, 32'hffff_ffff, 1'b0);
    add_cmd(CMD_DELETE, 32'h7fff_ffff, 1'b0);
    add_cmd(CMD_DELETE, 32'd12345, 1'b0);
    add_cmd(CMD_READ,   $urandom, 1'b0);
    add_cmd(CMD_DELETE, 32'h8000_0000, 1'b0);
    add_cmd(CMD_DELETE, 32'h0000_0000, 1'b0);
    add_cmd(CMD_READ,   $urandom, 1'b0);

    // random: alternate filling past full and draining to empty
    grow = 1'b1;
    full_tries = 0;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (grow && shadow_vals.size() == LIST_DEPTH && full_tries >= 2) begin
        grow = 1'b0;
      end else if (!grow && shadow_vals.size() == 0) begin
        grow = 1'b1;
        full_tries = 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 18) rcmd = CMD_READ;
      else if (roll < (grow ? 80 : 34)) rcmd = $urandom_range(0, 1) ? CMD_HEAD : CMD_TAIL;
      else rcmd = CMD_DELETE;
      if (rcmd == CMD_DELETE && shadow_vals.size() > 0 && $urandom_range(0, 9) < 7)
        rval = shadow_vals[$urandom_range(0, shadow_vals.size() - 1)];
      else
        rval = pick_value();
      if ((rcmd == CMD_HEAD || rcmd == CMD_TAIL) && shadow_vals.size() == LIST_DEPTH)
        full_tries++;
      add_cmd(rcmd, rval, n % 100 == 0);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    cycles = 10;
    done = 1'b0;
    while (!done && cycles < CYCLE_LIMIT) begin
      @(negedge clk);
      cycles++;
      done = cmd_q.size() == 0 && !s_axis_tvalid && outstanding == 0;
    end

    if (!done) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, result_q.size());
      $display("status: fail");
      $finish;
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (result_q.size() != 0)
        note_failure($sformatf("%0d expected items never arrived", result_q.size()));
      $display("ran %0d commands giving %0d result items in %0d cycles",
               cmd_count, result_count, cycles);
      $display("including %0d full refusals, %0d missed deletes, %0d empty reads; %0d errors",
               full_count, miss_count, empty_count, error_count);
      if (error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
    end
  end

endmodule
